// ----- hw/rtl/sae_pkg.sv -----
`timescale 1ns / 1ps

package sae_pkg;

    localparam int MAX_TEXT = 4096;
    localparam int ALPHABET = 26;
    localparam int ST_W     = 13;
    localparam int SYM_W    = 5;
    localparam int TR_AW    = ST_W + SYM_W;
    localparam int DIST_W   = 24;

    localparam logic [ST_W-1:0]  MAX_TEXT_C = ST_W'(MAX_TEXT);
    localparam logic [SYM_W-1:0] LAST_SYM   = SYM_W'(ALPHABET - 1);
    localparam logic [SYM_W-1:0] NUM_SYM    = SYM_W'(ALPHABET);

    localparam logic CMD_APPEND = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

endpackage

// ----- hw/rtl/sae_ram.sv -----
`timescale 1ns / 1ps

module sae_ram #(
    parameter int AW = 13,
    parameter int DW = 13
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [0:(1 << AW)-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hw/rtl/suffix_automaton_engine.sv -----
`timescale 1ns / 1ps

// Online suffix automaton builder with substring checks.
// Input words arrive on s_axis: tdata carries the symbol, tuser the command
// (0 append, 1 query) and tlast marks the final symbol of a query string.
// Each input word yields exactly one result word on m_axis: tdata carries the
// distinct substring total, the number of states and the text length, tuser
// carries the matched and text-full flags, and tlast ends a query string.
// One word is processed at a time; s_axis_tready is low while it is at work.
// All table accesses share one read port per memory, and a new row of 26
// transitions is cleared or copied one entry per cycle. Reset clears the
// text length, the distinct total, the query position and the root row of
// transitions at once and sets the state count to one, so no clearing pass
// is needed. If the receiver stalls, the result in the output register stays
// there until it is taken, and a word that finishes meanwhile waits with its
// result and holds off the next word until then.
// Once 4096 symbols are appended, further appends are refused and flagged.

module suffix_automaton_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [4:0] symbol
    input  logic        s_axis_tuser,   // [0] cmd
    input  logic        s_axis_tlast,   // query_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // [23:0] distinct_total, [36:24] states_used,
                                        // [49:37] text_length
    output logic [1:0]  m_axis_tuser,   // [0] matched, [1] text_full
    output logic        m_axis_tlast    // query_done
);

    import sae_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_ALEN, S_CLR, S_WTR, S_WLK, S_CLP, S_CLQ, S_CLKQ,
        S_CP, S_RTR, S_RLK, S_RFIX, S_RFIX2, S_FIN, S_QRD, S_OUT
    } state_t;

    state_t state_reg, state_next;

    logic [ST_W-1:0]   cur_reg, cur_next, p_reg, p_next, q_reg, q_next;
    logic [ST_W-1:0]   cl_reg, cl_next, lp_reg, lp_next;
    logic [ST_W-1:0]   len_cur_reg, len_cur_next, link_len_reg, link_len_next;
    logic [ST_W-1:0]   last_reg, last_next, total_reg, total_next;
    logic [ST_W-1:0]   app_reg, app_next, qpos_reg, qpos_next;
    logic [DIST_W-1:0] dist_reg, dist_next;
    logic [SYM_W-1:0]  k_reg, k_next, sym_reg, sym_next;
    logic              qend_reg, qend_next, qfail_reg, qfail_next;
    logic              res_m_reg, res_m_next, res_d_reg, res_d_next;
    logic              res_f_reg, res_f_next;
    logic [ALPHABET-1:0] rv_reg, rv_next;
    logic              ov_reg, ov_next;
    logic [55:0]       od_reg, od_next;
    logic [1:0]        ou_reg, ou_next;
    logic              ol_reg, ol_next;

    logic              tr_we, ln_we, lk_we;
    logic [TR_AW-1:0]  tr_waddr, tr_raddr;
    logic [ST_W-1:0]   tr_wdata, ln_waddr, ln_wdata, ln_raddr, lk_waddr, lk_wdata, lk_raddr;
    logic [ST_W-1:0]   tr_rdata, ln_rdata, lk_rdata, tr_val, ln_val, lk_val;
    logic              tr_zero_reg, ln_zero_reg, lk_zero_reg, tr_zero_now;
    logic [SYM_W-1:0]  in_sym, rd_col;
    logic              q_fail_new;

    sae_ram #(.AW(TR_AW), .DW(ST_W)) u_trans (
        .clk(clk), .we(tr_we), .waddr(tr_waddr), .wdata(tr_wdata),
        .raddr(tr_raddr), .rdata(tr_rdata)
    );

    sae_ram #(.AW(ST_W), .DW(ST_W)) u_len (
        .clk(clk), .we(ln_we), .waddr(ln_waddr), .wdata(ln_wdata),
        .raddr(ln_raddr), .rdata(ln_rdata)
    );

    sae_ram #(.AW(ST_W), .DW(ST_W)) u_link (
        .clk(clk), .we(lk_we), .waddr(lk_waddr), .wdata(lk_wdata),
        .raddr(lk_raddr), .rdata(lk_rdata)
    );

    assign in_sym = s_axis_tdata[SYM_W-1:0];
    assign rd_col = tr_raddr[SYM_W-1:0];
    assign tr_zero_now = (tr_raddr[TR_AW-1:SYM_W] == '0) &&
                         ((rd_col < NUM_SYM) ? !rv_reg[rd_col] : 1'b1);
    assign tr_val = tr_zero_reg ? '0 : tr_rdata;
    assign ln_val = ln_zero_reg ? '0 : ln_rdata;
    assign lk_val = lk_zero_reg ? '0 : lk_rdata;
    assign q_fail_new = (tr_val == '0);

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = od_reg;
    assign m_axis_tuser  = ou_reg;
    assign m_axis_tlast  = ol_reg;

    always_comb
    begin
        state_next = state_reg;
        cur_next = cur_reg;
        p_next = p_reg;
        q_next = q_reg;
        cl_next = cl_reg;
        lp_next = lp_reg;
        len_cur_next = len_cur_reg;
        link_len_next = link_len_reg;
        last_next = last_reg;
        total_next = total_reg;
        app_next = app_reg;
        qpos_next = qpos_reg;
        dist_next = dist_reg;
        k_next = k_reg;
        sym_next = sym_reg;
        qend_next = qend_reg;
        qfail_next = qfail_reg;
        res_m_next = res_m_reg;
        res_d_next = res_d_reg;
        res_f_next = res_f_reg;
        rv_next = rv_reg;
        ov_next = ov_reg;
        od_next = od_reg;
        ou_next = ou_reg;
        ol_next = ol_reg;
        tr_we = 1'b0;
        tr_waddr = '0;
        tr_wdata = '0;
        tr_raddr = '0;
        ln_we = 1'b0;
        ln_waddr = '0;
        ln_wdata = '0;
        ln_raddr = '0;
        lk_we = 1'b0;
        lk_waddr = '0;
        lk_wdata = '0;
        lk_raddr = '0;

        if (ov_reg && m_axis_tready)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    sym_next = in_sym;
                    qend_next = s_axis_tlast;
                    res_m_next = 1'b0;
                    res_d_next = 1'b0;
                    res_f_next = 1'b0;
                    if (s_axis_tuser == CMD_APPEND)
                    begin
                        qpos_next = '0;
                        qfail_next = 1'b0;
                        if (app_reg == MAX_TEXT_C)
                        begin
                            res_f_next = 1'b1;
                            state_next = S_OUT;
                        end
                        else if (in_sym >= NUM_SYM)
                        begin
                            state_next = S_OUT;
                        end
                        else
                        begin
                            cur_next = total_reg;
                            total_next = total_reg + 1'b1;
                            p_next = last_reg;
                            ln_raddr = last_reg;
                            state_next = S_ALEN;
                        end
                    end
                    else if (qfail_reg || in_sym >= NUM_SYM)
                    begin
                        res_d_next = s_axis_tlast;
                        qfail_next = s_axis_tlast ? 1'b0 : 1'b1;
                        if (s_axis_tlast)
                        begin
                            qpos_next = '0;
                        end
                        state_next = S_OUT;
                    end
                    else
                    begin
                        tr_raddr = {qpos_reg, in_sym};
                        state_next = S_QRD;
                    end
                end
            end
            S_QRD:
            begin
                res_m_next = !q_fail_new;
                res_d_next = qend_reg;
                if (qend_reg)
                begin
                    qpos_next = '0;
                    qfail_next = 1'b0;
                end
                else if (q_fail_new)
                begin
                    qfail_next = 1'b1;
                end
                else
                begin
                    qpos_next = tr_val;
                end
                state_next = S_OUT;
            end
            S_ALEN:
            begin
                len_cur_next = ln_val + 1'b1;
                ln_we = 1'b1;
                ln_waddr = cur_reg;
                ln_wdata = ln_val + 1'b1;
                k_next = '0;
                state_next = S_CLR;
            end
            S_CLR:
            begin
                tr_we = 1'b1;
                tr_waddr = {cur_reg, k_reg};
                tr_wdata = '0;
                k_next = k_reg + 1'b1;
                if (k_reg == LAST_SYM)
                begin
                    tr_raddr = {p_reg, sym_reg};
                    state_next = S_WTR;
                end
            end
            S_WTR:
            begin
                if (tr_val == '0)
                begin
                    tr_we = 1'b1;
                    tr_waddr = {p_reg, sym_reg};
                    tr_wdata = cur_reg;
                    if (p_reg == '0)
                    begin
                        rv_next[sym_reg] = 1'b1;
                        lk_we = 1'b1;
                        lk_waddr = cur_reg;
                        lk_wdata = '0;
                        link_len_next = '0;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        lk_raddr = p_reg;
                        state_next = S_WLK;
                    end
                end
                else
                begin
                    q_next = tr_val;
                    ln_raddr = p_reg;
                    state_next = S_CLP;
                end
            end
            S_WLK:
            begin
                p_next = lk_val;
                tr_raddr = {lk_val, sym_reg};
                state_next = S_WTR;
            end
            S_CLP:
            begin
                lp_next = ln_val;
                ln_raddr = q_reg;
                state_next = S_CLQ;
            end
            S_CLQ:
            begin
                if (lp_reg + 1'b1 == ln_val)
                begin
                    lk_we = 1'b1;
                    lk_waddr = cur_reg;
                    lk_wdata = q_reg;
                    link_len_next = ln_val;
                    state_next = S_FIN;
                end
                else
                begin
                    cl_next = total_reg;
                    total_next = total_reg + 1'b1;
                    ln_we = 1'b1;
                    ln_waddr = total_reg;
                    ln_wdata = lp_reg + 1'b1;
                    lk_raddr = q_reg;
                    state_next = S_CLKQ;
                end
            end
            S_CLKQ:
            begin
                lk_we = 1'b1;
                lk_waddr = cl_reg;
                lk_wdata = lk_val;
                k_next = '0;
                tr_raddr = {q_reg, {SYM_W{1'b0}}};
                state_next = S_CP;
            end
            S_CP:
            begin
                tr_we = 1'b1;
                tr_waddr = {cl_reg, k_reg};
                tr_wdata = tr_val;
                if (k_reg == LAST_SYM)
                begin
                    tr_raddr = {p_reg, sym_reg};
                    state_next = S_RTR;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                    tr_raddr = {q_reg, k_reg + 1'b1};
                end
            end
            S_RTR:
            begin
                if (tr_val == q_reg)
                begin
                    tr_we = 1'b1;
                    tr_waddr = {p_reg, sym_reg};
                    tr_wdata = cl_reg;
                    if (p_reg == '0)
                    begin
                        state_next = S_RFIX;
                    end
                    else
                    begin
                        lk_raddr = p_reg;
                        state_next = S_RLK;
                    end
                end
                else
                begin
                    state_next = S_RFIX;
                end
            end
            S_RLK:
            begin
                p_next = lk_val;
                tr_raddr = {lk_val, sym_reg};
                state_next = S_RTR;
            end
            S_RFIX:
            begin
                lk_we = 1'b1;
                lk_waddr = q_reg;
                lk_wdata = cl_reg;
                state_next = S_RFIX2;
            end
            S_RFIX2:
            begin
                lk_we = 1'b1;
                lk_waddr = cur_reg;
                lk_wdata = cl_reg;
                link_len_next = lp_reg + 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                dist_next = dist_reg + DIST_W'(len_cur_reg) - DIST_W'(link_len_reg);
                last_next = cur_reg;
                app_next = app_reg + 1'b1;
                res_m_next = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!ov_reg || m_axis_tready)
                begin
                    ov_next = 1'b1;
                    od_next = {6'd0, app_reg, total_reg, dist_reg};
                    ou_next = {res_f_reg, res_m_reg};
                    ol_next = res_d_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            last_reg <= '0;
            total_reg <= ST_W'(1);
            app_reg <= '0;
            qpos_reg <= '0;
            dist_reg <= '0;
            qfail_reg <= 1'b0;
            rv_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            last_reg <= last_next;
            total_reg <= total_next;
            app_reg <= app_next;
            qpos_reg <= qpos_next;
            dist_reg <= dist_next;
            qfail_reg <= qfail_next;
            rv_reg <= rv_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        p_reg <= p_next;
        q_reg <= q_next;
        cl_reg <= cl_next;
        lp_reg <= lp_next;
        len_cur_reg <= len_cur_next;
        link_len_reg <= link_len_next;
        k_reg <= k_next;
        sym_reg <= sym_next;
        qend_reg <= qend_next;
        res_m_reg <= res_m_next;
        res_d_reg <= res_d_next;
        res_f_reg <= res_f_next;
        od_reg <= od_next;
        ou_reg <= ou_next;
        ol_reg <= ol_next;
        tr_zero_reg <= tr_zero_now;
        ln_zero_reg <= (ln_raddr == '0);
        lk_zero_reg <= (lk_raddr == '0);
    end

    a_total_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg != '0)
        else $error("state count dropped to zero");

    a_text_bound: assert property (@(posedge clk) disable iff (!rst_n)
        app_reg <= MAX_TEXT_C)
        else $error("text length beyond maximum");

    a_state_bound: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, total_reg} <= {app_reg, 1'b0} + 14'd2)
        else $error("more states than the text allows");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("accepted a word while busy");

endmodule

// ----- verif/sae_checker.sv -----
`timescale 1ns / 1ps

module sae_checker
    import sae_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    input  logic        s_axis_tuser,
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [55:0] m_axis_tdata,
    input  logic [1:0]  m_axis_tuser,
    input  logic        m_axis_tlast,
    output int          errors,
    output int          pending
);

    localparam int NST = 2 * MAX_TEXT + 2;

    typedef struct packed {
        logic              matched;
        logic              done;
        logic              full;
        logic [DIST_W-1:0] distinct;
        logic [ST_W-1:0]   states;
        logic [ST_W-1:0]   length;
    } sae_result_t;

    int          goto_tbl [NST][ALPHABET];
    int          link_of [NST];
    int          len_of [NST];
    int          last_st;
    int          n_states;
    int          distinct_sum;
    int          text_len;
    int          walk_pos;
    bit          walk_dead;
    sae_result_t expected_results [$];

    initial
    begin
        for (int s = 0; s < NST; s++)
        begin
            link_of[s] = 0;
            len_of[s]  = 0;
            for (int a = 0; a < ALPHABET; a++)
            begin
                goto_tbl[s][a] = 0;
            end
        end
        last_st      = 0;
        n_states     = 1;
        distinct_sum = 0;
        text_len     = 0;
        walk_pos     = 0;
        walk_dead    = 0;
        errors       = 0;
        pending      = 0;
    end

    function automatic void extend_automaton(int c);
        int  cur;
        int  p;
        int  q;
        int  cl;
        bit  walking;
        cur = n_states;
        n_states++;
        p = last_st;
        walking = 1;
        len_of[cur] = len_of[last_st] + 1;
        for (int a = 0; a < ALPHABET; a++)
        begin
            goto_tbl[cur][a] = 0;
        end
        while (walking && goto_tbl[p][c] == 0)
        begin
            goto_tbl[p][c] = cur;
            if (p == 0)
                walking = 0;
            else
                p = link_of[p];
        end
        if (!walking)
        begin
            link_of[cur] = 0;
        end
        else
        begin
            q = goto_tbl[p][c];
            if (len_of[p] + 1 == len_of[q])
            begin
                link_of[cur] = q;
            end
            else
            begin
                cl = n_states;
                n_states++;
                for (int a = 0; a < ALPHABET; a++)
                begin
                    goto_tbl[cl][a] = goto_tbl[q][a];
                end
                len_of[cl]  = len_of[p] + 1;
                link_of[cl] = link_of[q];
                while (walking && goto_tbl[p][c] == q)
                begin
                    goto_tbl[p][c] = cl;
                    if (p == 0)
                        walking = 0;
                    else
                        p = link_of[p];
                end
                link_of[q]   = cl;
                link_of[cur] = cl;
            end
        end
        last_st = cur;
        distinct_sum = (distinct_sum + len_of[cur] - len_of[link_of[cur]]) & 24'hFFFFFF;
    endfunction

    function automatic sae_result_t predict_word(logic cmd, logic [4:0] sym, logic qend);
        sae_result_t r;
        int          nxt;
        r = '0;
        if (cmd == CMD_APPEND)
        begin
            walk_pos  = 0;
            walk_dead = 0;
            if (text_len >= MAX_TEXT)
            begin
                r.full = 1;
            end
            else if (sym < NUM_SYM)
            begin
                extend_automaton(int'(sym));
                text_len++;
                r.matched = 1;
            end
        end
        else
        begin
            if (!walk_dead)
            begin
                nxt = (sym < NUM_SYM) ? goto_tbl[walk_pos][sym] : 0;
                if (nxt == 0)
                    walk_dead = 1;
                else
                    walk_pos = nxt;
            end
            r.matched = !walk_dead;
            if (qend)
            begin
                r.done    = 1;
                walk_pos  = 0;
                walk_dead = 0;
            end
        end
        r.distinct = DIST_W'(distinct_sum);
        r.states   = ST_W'(n_states);
        r.length   = ST_W'(text_len);
        return r;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    always @(posedge clk)
    begin
        sae_result_t e;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            expected_results = {expected_results,
                                predict_word(s_axis_tuser, s_axis_tdata[4:0],
                                             s_axis_tlast)};
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_results.size() == 0)
            begin
                report("unexpected result word", 1, 0);
            end
            else
            begin
                e = expected_results.pop_front();
                if (m_axis_tuser[0] !== e.matched)
                    report("matched", m_axis_tuser[0], e.matched);
                if (m_axis_tlast !== e.done)
                    report("query_done", m_axis_tlast, e.done);
                if (m_axis_tuser[1] !== e.full)
                    report("text_full", m_axis_tuser[1], e.full);
                if (m_axis_tdata[23:0] !== e.distinct)
                    report("distinct_total", m_axis_tdata[23:0], e.distinct);
                if (m_axis_tdata[36:24] !== e.states)
                    report("states_used", m_axis_tdata[36:24], e.states);
                if (m_axis_tdata[49:37] !== e.length)
                    report("text_length", m_axis_tdata[49:37], e.length);
                if (m_axis_tdata[55:50] !== 6'd0)
                    report("tdata padding", m_axis_tdata[55:50], 0);
            end
        end
        pending = expected_results.size();
    end

endmodule

// ----- verif/tb_suffix_automaton_engine.sv -----
`timescale 1ns / 1ps

module tb_suffix_automaton_engine;

    import sae_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tuser;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;
    int          errors;
    int          pending;
    bit          quiet;
    int          stall_left;
    int          sent_count;
    int          text_syms [$];

    suffix_automaton_engine u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    sae_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast),
        .errors       (errors),
        .pending      (pending)
    );

    initial
    begin
        clk = 0;
    end

    always
    begin
        #4 clk = 1;
        #4 clk = 0;
    end

    initial
    begin
        #50ms;
        $display("tb_suffix_automaton_engine: FAIL");
        $finish;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready = 0;
            stall_left = 0;
        end
        else if (stall_left > 0)
        begin
            m_axis_tready = 0;
            stall_left--;
        end
        else
        begin
            m_axis_tready = 1;
            if (!quiet && $urandom_range(0, 7) == 0)
                stall_left = gap_len();
        end
    end

    task automatic send(logic cmd, logic [4:0] sym, logic qend);
        s_axis_tvalid = 1;
        s_axis_tdata  = {3'b000, sym};
        s_axis_tuser  = cmd;
        s_axis_tlast  = qend;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
        s_axis_tvalid = 0;
        sent_count++;
        repeat (gap_len()) @(negedge clk);
        if (cmd == CMD_APPEND && sym < NUM_SYM && text_syms.size() < MAX_TEXT)
            text_syms = {text_syms, int'(sym)};
    endtask

    task automatic append_letter(int top);
        send(CMD_APPEND, 5'($urandom_range(0, top)), 1'($urandom_range(0, 1)));
    endtask

    task automatic query_string();
        int start;
        int n;
        logic [4:0] sym;
        bit cut;
        if (text_syms.size() == 0 || $urandom_range(0, 4) == 0)
        begin
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++)
            begin
                send(CMD_QUERY, 5'($urandom_range(0, 31)), i == n - 1);
            end
            return;
        end
        start = $urandom_range(0, text_syms.size() - 1);
        n = $urandom_range(1, (text_syms.size() - start < 8) ? text_syms.size() - start : 8);
        cut = ($urandom_range(0, 9) == 0);
        for (int i = 0; i < n; i++)
        begin
            sym = 5'(text_syms[start + i]);
            if ($urandom_range(0, 11) == 0)
                sym = 5'($urandom_range(0, 31));
            if (cut && i == n - 1)
                break;
            send(CMD_QUERY, sym, i == n - 1);
        end
    endtask

    initial
    begin
        int top;
        rst_n         = 0;
        s_axis_tvalid = 0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_APPEND;
        s_axis_tlast  = 0;
        m_axis_tready = 0;
        quiet         = 0;
        stall_left    = 0;
        sent_count    = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        send(CMD_QUERY, 5'd0, 1);
        send(CMD_QUERY, 5'd31, 1);
        send(CMD_APPEND, 5'd0, 0);
        send(CMD_APPEND, LAST_SYM, 1);
        send(CMD_APPEND, 5'd31, 0);
        send(CMD_APPEND, NUM_SYM, 0);
        send(CMD_APPEND, 5'd0, 0);
        send(CMD_APPEND, 5'd0, 0);
        send(CMD_QUERY, 5'd0, 0);
        send(CMD_QUERY, LAST_SYM, 1);
        send(CMD_QUERY, 5'd0, 0);
        send(CMD_QUERY, 5'd1, 0);
        send(CMD_QUERY, 5'd0, 1);
        send(CMD_QUERY, 5'd0, 0);
        send(CMD_APPEND, 5'd1, 0);
        send(CMD_QUERY, LAST_SYM, 0);
        send(CMD_QUERY, 5'd31, 0);
        send(CMD_QUERY, 5'd0, 1);

        wait (pending == 0);
        @(negedge clk);

        while (sent_count < 1200)
        begin
            quiet = (sent_count > 600 && sent_count < 700);
            top = ($urandom_range(0, 7) == 0) ? 25 : $urandom_range(1, 3);
            if ($urandom_range(0, 2) == 0)
                query_string();
            else if ($urandom_range(0, 19) == 0)
                send(CMD_APPEND, 5'($urandom_range(26, 31)), 0);
            else
                append_letter(top);
        end
        quiet = 0;

        send(CMD_APPEND, 5'd31, 1);
        for (int i = 0; i < 12; i++)
        begin
            if ($urandom_range(0, 3) == 0)
                append_letter(25);
            else
                query_string();
        end

        wait (pending == 0);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("tb_suffix_automaton_engine: PASS");
        else
            $display("tb_suffix_automaton_engine: FAIL");
        $finish;
    end

endmodule
